### src/fdpw_pkg.sv
// ----------------------------------------------------------------------------
// fdpw_pkg: shared types, constants and helpers for the filled dot writer
// Register indexes, field widths, the register bank type and colour packing.
// ----------------------------------------------------------------------------
package fdpw_pkg;

  // Fixed field widths
  localparam int PIX_W    = 12;
  localparam int STRIDE_W = 14;
  localparam int OFFS_W   = 20;
  localparam int LENS_W   = 12;
  localparam int CHAN_W   = 8;
  localparam int WORD_W   = 32;
  localparam int HALF_W   = 16;
  localparam int ADDR_W   = 26;
  localparam int LIMIT_W  = STRIDE_W + PIX_W;
  localparam int PROD_W   = PIX_W + 1 + STRIDE_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int SIZE_W   = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Caps and fixed values
  localparam int MAX_WRITES = 64;
  localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'hFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_X   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_Y   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSETS = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTHS = 8'd7;

  // Reset values of the colour layout registers
  localparam logic              MODE_RESET    = 1'b1;
  localparam logic [OFFS_W-1:0] OFFSETS_RESET = 20'hC0110;
  localparam logic [LENS_W-1:0] LENGTHS_RESET = 12'h888;

  typedef struct packed {
    logic [PIX_W-1:0]    width_px;
    logic [PIX_W-1:0]    height_px;
    logic [PIX_W-1:0]    pan_x;
    logic [PIX_W-1:0]    pan_y;
    logic [STRIDE_W-1:0] line_bytes;
    logic                pixel_mode;
    logic [OFFS_W-1:0]   channel_offsets;
    logic [LENS_W-1:0]   channel_lengths;
  } cfg_t;

  // Truncate one 8-bit channel to len bits (len above 8 counts as 8)
  function automatic logic [CHAN_W-1:0] trunc_chan(input logic [CHAN_W-1:0] v,
                                                   input logic [3:0] len);
    logic [3:0] l;
    l = (len > 4'd8) ? 4'd8 : len;
    return v >> (4'd8 - l);
  endfunction

  // Build the pixel word for the current layout
  function automatic logic [WORD_W-1:0] pack_word(input cfg_t c,
                                                  input logic [CHAN_W-1:0] r,
                                                  input logic [CHAN_W-1:0] g,
                                                  input logic [CHAN_W-1:0] b);
    logic [4:0] ro, go, bo, ao;
    logic [WORD_W-1:0] w;
    ro = c.channel_offsets[4:0];
    go = c.channel_offsets[9:5];
    bo = c.channel_offsets[14:10];
    ao = c.channel_offsets[19:15];
    if (c.pixel_mode) begin
      w = (WORD_W'(ALPHA_FULL) << ao) | (WORD_W'(r) << ro) |
          (WORD_W'(g) << go) | (WORD_W'(b) << bo);
    end else begin
      w = (WORD_W'(trunc_chan(r, c.channel_lengths[3:0])) << ro) |
          (WORD_W'(trunc_chan(g, c.channel_lengths[7:4])) << go) |
          (WORD_W'(trunc_chan(b, c.channel_lengths[11:8])) << bo);
      w = {{(WORD_W-HALF_W){1'b0}}, w[HALF_W-1:0]};
    end
    return w;
  endfunction

endpackage

### src/fdpw_cmd_if.sv
// ----------------------------------------------------------------------------
// fdpw_cmd_if: dot command channel
// Valid/ready channel carrying one dot command per transaction.
// ----------------------------------------------------------------------------
interface fdpw_cmd_if #(
  parameter int COORD_BITS = 13
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [3:0]                   diameter;
  logic [7:0]                   red;
  logic [7:0]                   green;
  logic [7:0]                   blue;

  modport source (output valid, center_x, center_y, diameter, red, green, blue,
                  input ready);
  modport sink   (input valid, center_x, center_y, diameter, red, green, blue,
                  output ready);
endinterface

### src/fdpw_wr_if.sv
// ----------------------------------------------------------------------------
// fdpw_wr_if: framebuffer write channel
// Valid/ready channel carrying one pixel write per transaction.
// ----------------------------------------------------------------------------
interface fdpw_wr_if;
  logic        valid;
  logic        ready;
  logic [25:0] byte_address;
  logic [31:0] pixel_word;
  logic        wide_write;
  logic        last_write;

  modport source (output valid, byte_address, pixel_word, wide_write, last_write,
                  input ready);
  modport sink   (input valid, byte_address, pixel_word, wide_write, last_write,
                  output ready);
endinterface

### src/fdpw_cfg_if.sv
// ----------------------------------------------------------------------------
// fdpw_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface fdpw_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/filled_dot_pixel_writer.sv
// ----------------------------------------------------------------------------
// filled_dot_pixel_writer: filled dot plotter for a linear framebuffer
// Turns dot commands into byte-addressed pixel writes for 16/32-bit modes.
// ----------------------------------------------------------------------------
// A dot of size s (clamped to MAX_DOT_SIZE) has radius h = s/2 and is scanned
// as a 2h by 2h square of offsets, one candidate per clock in the scan unit
// unless the write channel stalls, followed by a flush state and a return to
// idle that loads the next command; a dot of size 0 or 1 goes straight to the
// flush state. Each write passes through three pipeline stages and is held
// back by one point, and the last write of a dot carries last_write. A
// two-entry command queue lets new dots be taken while the current one is
// still being drawn. Register writes should only be issued while no dot is
// in progress.
module filled_dot_pixel_writer #(
  parameter int MAX_DOT_SIZE = 8,
  parameter int COORD_BITS   = 13
) (
  input  logic       clk,
  input  logic       rst,
  fdpw_cmd_if.sink   cmd,
  fdpw_wr_if.source  wr,
  fdpw_cfg_if.sink   cfg
);
  import fdpw_pkg::*;

  localparam int HMAX    = MAX_DOT_SIZE / 2;
  localparam int H_W     = $clog2(HMAX + 1);
  localparam int ENTRY_W = 2 * COORD_BITS + H_W + WORD_W;

  cfg_t               regs;
  logic [LIMIT_W-1:0] limit;
  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               q_valid, q_pop;
  logic [ENTRY_W-1:0] q_data;

  // Register bank
  fdpw_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .regs  (regs),
    .limit (limit)
  );

  // Command intake
  fdpw_front #(
    .MAX_DOT_SIZE (MAX_DOT_SIZE),
    .COORD_BITS   (COORD_BITS),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .cmd        (cmd),
    .regs       (regs),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Command queue
  fdpw_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_data  (q_data)
  );

  // Scan and write issue
  fdpw_back #(
    .MAX_DOT_SIZE (MAX_DOT_SIZE),
    .COORD_BITS   (COORD_BITS),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .limit   (limit),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .wr      (wr)
  );

endmodule

### src/fdpw_regs.sv
// ----------------------------------------------------------------------------
// fdpw_regs: configuration register bank
// Holds the screen and colour layout registers and the buffer size limit.
// ----------------------------------------------------------------------------
module fdpw_regs (
  input  logic           clk,
  input  logic           rst,
  fdpw_cfg_if.sink       cfg,
  output fdpw_pkg::cfg_t regs,
  output logic [fdpw_pkg::LIMIT_W-1:0] limit
);
  import fdpw_pkg::*;

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.width_px        <= '0;
      regs.height_px       <= '0;
      regs.pan_x           <= '0;
      regs.pan_y           <= '0;
      regs.line_bytes      <= '0;
      regs.pixel_mode      <= MODE_RESET;
      regs.channel_offsets <= OFFSETS_RESET;
      regs.channel_lengths <= LENGTHS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WIDTH:   regs.width_px        <= cfg.data[PIX_W-1:0];
        REG_HEIGHT:  regs.height_px       <= cfg.data[PIX_W-1:0];
        REG_PAN_X:   regs.pan_x           <= cfg.data[PIX_W-1:0];
        REG_PAN_Y:   regs.pan_y           <= cfg.data[PIX_W-1:0];
        REG_STRIDE:  regs.line_bytes      <= cfg.data[STRIDE_W-1:0];
        REG_MODE:    regs.pixel_mode      <= cfg.data[0];
        REG_OFFSETS: regs.channel_offsets <= cfg.data[OFFS_W-1:0];
        REG_LENGTHS: regs.channel_lengths <= cfg.data[LENS_W-1:0];
        default: ;
      endcase
    end
  end

  // Buffer size, refreshed every cycle from the registers
  always_ff @(posedge clk) begin
    limit <= LIMIT_W'(regs.line_bytes) * LIMIT_W'(regs.height_px);
  end

endmodule

### src/fdpw_front.sv
// ----------------------------------------------------------------------------
// fdpw_front: command intake
// Accepts dot commands, clamps the size to a radius and packs the colour.
// ----------------------------------------------------------------------------
module fdpw_front #(
  parameter int MAX_DOT_SIZE = 8,
  parameter int COORD_BITS   = 13,
  parameter int ENTRY_W      = 61
) (
  fdpw_cmd_if.sink       cmd,
  input  fdpw_pkg::cfg_t regs,
  input  logic           push_ready,
  output logic           push_valid,
  output logic [ENTRY_W-1:0] push_data
);
  import fdpw_pkg::*;

  localparam int HMAX = MAX_DOT_SIZE / 2;
  localparam int H_W  = $clog2(HMAX + 1);
  localparam int SZ_W = $clog2(MAX_DOT_SIZE + 1);

  logic [SZ_W-1:0]   size_sat;
  logic [H_W-1:0]    radius;
  logic [WORD_W-1:0] word;

  // Handshake straight through to the queue
  assign cmd.ready  = push_ready;
  assign push_valid = cmd.valid;

  // Size clamp and radius
  assign size_sat = (32'(cmd.diameter) > MAX_DOT_SIZE) ? SZ_W'(MAX_DOT_SIZE)
                                                       : SZ_W'(cmd.diameter);
  assign radius   = H_W'(size_sat >> 1);

  // Colour packing for the current layout
  assign word = pack_word(regs, cmd.red, cmd.green, cmd.blue);

  assign push_data = {cmd.center_x, cmd.center_y, radius, word};

endmodule

### src/fdpw_queue.sv
// ----------------------------------------------------------------------------
// fdpw_queue: command queue
// Two-entry first-word-fall-through queue between intake and scan.
// ----------------------------------------------------------------------------
module fdpw_queue #(
  parameter int DATA_W = 61
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_pop,
  output logic [DATA_W-1:0] out_data
);
  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;
  logic              do_push;
  logic              do_pop;

  assign in_ready  = (count != (PTR_W+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_pop && out_valid;
  assign out_data  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/fdpw_back.sv
// ----------------------------------------------------------------------------
// fdpw_back: dot scan and write issue
// Walks the offset square, filters points through a three-stage pipeline and
// holds one write back so the final write of a dot can be flagged.
// ----------------------------------------------------------------------------
module fdpw_back #(
  parameter int MAX_DOT_SIZE = 8,
  parameter int COORD_BITS   = 13,
  parameter int ENTRY_W      = 61
) (
  input  logic           clk,
  input  logic           rst,
  input  fdpw_pkg::cfg_t regs,
  input  logic [fdpw_pkg::LIMIT_W-1:0] limit,
  input  logic           q_valid,
  input  logic [ENTRY_W-1:0] q_data,
  output logic           q_pop,
  fdpw_wr_if.source      wr
);
  import fdpw_pkg::*;

  localparam int HMAX  = MAX_DOT_SIZE / 2;
  localparam int H_W   = $clog2(HMAX + 1);
  localparam int OFF_W = $clog2(HMAX) + 1;
  localparam int SQ_W  = 2 * OFF_W + 1;
  localparam int XY_W  = COORD_BITS + 1;
  localparam int CMP_W = (XY_W > PIX_W + 1) ? XY_W : PIX_W + 1;
  localparam int CNT_W = $clog2(MAX_WRITES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // Scan registers
  logic [1:0]                   state;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic [H_W-1:0]               radius;
  logic [WORD_W-1:0]            word;
  logic signed [OFF_W-1:0]      dx;
  logic signed [OFF_W-1:0]      dy;

  // Queue entry fields
  logic signed [COORD_BITS-1:0] q_cx;
  logic signed [COORD_BITS-1:0] q_cy;
  logic [H_W-1:0]               q_radius;
  logic [WORD_W-1:0]            q_word;

  // Pipeline stages
  logic                    s1_valid, s1_flush, s1_inc;
  logic signed [XY_W-1:0]  s1_x, s1_y;
  logic [WORD_W-1:0]       s1_word;
  logic                    s2_valid, s2_flush, s2_ok;
  logic [SUM_W-1:0]        s2_addr;
  logic [WORD_W-1:0]       s2_word;
  logic                    s3_valid, s3_flush, s3_ok;
  logic [SUM_W-1:0]        s3_addr;
  logic [WORD_W-1:0]       s3_word;

  // Held write and write count
  logic                    pend_valid;
  logic [ADDR_W-1:0]       pend_addr;
  logic [WORD_W-1:0]       pend_word;
  logic [CNT_W-1:0]        count;

  // Combinational helpers
  logic signed [OFF_W-1:0]    neg_h, h_m1;
  logic signed [2*OFF_W-1:0]  dx_sq, dy_sq;
  logic [SQ_W-1:0]            dist_sq;
  logic [SQ_W-1:0]            h_sq;
  logic                       tok_valid, tok_flush, tok_inc;
  logic signed [XY_W-1:0]     tok_x, tok_y;
  logic [CMP_W-1:0]           x_mag, y_mag;
  logic                       x_in, y_in;
  logic [PIX_W:0]             xp, yp;
  logic [PIX_W+2:0]           term_x;
  logic [PROD_W-1:0]          prod;
  logic [SUM_W-1:0]           addr_calc;
  logic                       pass, need_out, out_free, adv;

  assign {q_cx, q_cy, q_radius, q_word} = q_data;
  assign q_pop = (state == ST_IDLE) && q_valid;

  // Offset bounds of the current dot
  assign neg_h = -OFF_W'(radius);
  assign h_m1  = OFF_W'(radius) - OFF_W'(1);

  // Circle test for the current offset
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;
  assign dist_sq = SQ_W'($unsigned(dx_sq)) + SQ_W'($unsigned(dy_sq));
  assign h_sq    = SQ_W'(radius) * SQ_W'(radius);

  assign tok_valid = (state == ST_SCAN) || (state == ST_FLUSH);
  assign tok_flush = (state == ST_FLUSH);
  assign tok_inc   = (dist_sq <= h_sq);
  assign tok_x     = XY_W'(cx) + XY_W'(dx);
  assign tok_y     = XY_W'(cy) + XY_W'(dy);

  // Screen bounds and address for stage 1
  assign x_mag = CMP_W'($unsigned(s1_x[XY_W-2:0]));
  assign y_mag = CMP_W'($unsigned(s1_y[XY_W-2:0]));
  assign x_in  = !s1_x[XY_W-1] && (x_mag < CMP_W'(regs.width_px));
  assign y_in  = !s1_y[XY_W-1] && (y_mag < CMP_W'(regs.height_px));
  assign xp    = {1'b0, x_mag[PIX_W-1:0]} + {1'b0, regs.pan_x};
  assign yp    = {1'b0, y_mag[PIX_W-1:0]} + {1'b0, regs.pan_y};
  assign term_x = regs.pixel_mode ? {xp, 2'b00} : {1'b0, xp, 1'b0};
  assign prod   = PROD_W'(yp) * PROD_W'(regs.line_bytes);
  assign addr_calc = SUM_W'(term_x) + SUM_W'(prod);

  // Commit decision for stage 3
  assign pass     = s3_ok && (s3_addr < SUM_W'(limit)) &&
                    (count < CNT_W'(MAX_WRITES));
  assign need_out = s3_valid && pend_valid && (s3_flush || pass);
  assign out_free = !wr.valid || wr.ready;
  assign adv      = !need_out || out_free;

  // Scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= (q_radius == '0) ? ST_FLUSH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (adv && (dy == h_m1) && (dx == h_m1)) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (adv) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Command fields and offset counters
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cx     <= q_cx;
      cy     <= q_cy;
      radius <= q_radius;
      word   <= q_word;
      dx     <= -OFF_W'(q_radius);
      dy     <= -OFF_W'(q_radius);
    end else if ((state == ST_SCAN) && adv) begin
      if (dy == h_m1) begin
        dy <= neg_h;
        dx <= dx + OFF_W'(1);
      end else begin
        dy <= dy + OFF_W'(1);
      end
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= tok_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_flush <= tok_flush;
      s1_inc   <= tok_inc;
      s1_x     <= tok_x;
      s1_y     <= tok_y;
      s1_word  <= word;
      s2_flush <= s1_flush;
      s2_ok    <= s1_inc && x_in && y_in;
      s2_addr  <= addr_calc;
      s2_word  <= s1_word;
      s3_flush <= s2_flush;
      s3_ok    <= s2_ok;
      s3_addr  <= s2_addr;
      s3_word  <= s2_word;
    end
  end

  // Held write, write count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      count      <= '0;
      wr.valid   <= 1'b0;
    end else begin
      if (adv && need_out) begin
        wr.valid <= 1'b1;
      end else if (wr.ready) begin
        wr.valid <= 1'b0;
      end
      if (adv && s3_valid) begin
        if (s3_flush) begin
          pend_valid <= 1'b0;
          count      <= '0;
        end else if (pass) begin
          pend_valid <= 1'b1;
          count      <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid && (s3_flush || pass)) begin
      if (pend_valid) begin
        wr.byte_address <= pend_addr;
        wr.pixel_word   <= pend_word;
        wr.wide_write   <= regs.pixel_mode;
        wr.last_write   <= s3_flush;
      end
      if (pass && !s3_flush) begin
        pend_addr <= s3_addr[ADDR_W-1:0];
        pend_word <= s3_word;
      end
    end
  end

endmodule

### bench/tb_filled_dot_pixel_writer.sv
// ----------------------------------------------------------------------------
// tb_filled_dot_pixel_writer: self-checking bench for the filled dot writer
// Dot commands go in from a queue, and every pixel write that comes back is
// checked in order against a predictor of the scan, clipping and colour
// packing. Screen layouts change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_filled_dot_pixel_writer;
  import fdpw_pkg::*;

  localparam int MAX_DIAMETER  = 8;
  localparam int COORD_W       = 13;
  localparam int SETTLE_CYCLES = 250;   // enough for two queued dots and one in flight
  localparam int END_CYCLES    = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASES        = 9;
  localparam int DOTS_PER_PHASE = 27;

  // Index that maps to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hF8;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {LAYOUT_TYPICAL, LAYOUT_FULL, LAYOUT_TINY} layout_kind_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [SIZE_W-1:0]  diameter;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
  } dot_t;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [WORD_W-1:0] pixel_word;
    logic              wide_write;
    logic              last_write;
  } pixel_write_t;

  logic clk;
  logic rst;

  fdpw_cmd_if #(.COORD_BITS(COORD_W)) cmd_ch ();
  fdpw_wr_if  wr_ch ();
  fdpw_cfg_if cfg_ch ();

  filled_dot_pixel_writer #(
    .MAX_DOT_SIZE(MAX_DIAMETER),
    .COORD_BITS  (COORD_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .wr (wr_ch),
    .cfg(cfg_ch)
  );

  // Bench state
  dot_t         dot_queue[$];        // dots waiting to be sent
  pixel_write_t pending_writes[$];   // predicted writes not yet seen
  cfg_t         shadow_cfg;          // register values as the block holds them
  bit           dot_showing = 1'b0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           fail_count = 0;
  int           quiet_cycles = 0;
  bit           progress;
  dot_t         taken_dot;
  pixel_write_t seen_write;
  pixel_write_t want_write;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Colour packing for the current layout
  function automatic logic [WORD_W-1:0] dot_colour(input logic [CHAN_W-1:0] r,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] b);
    logic [63:0]       w;
    logic [CHAN_W-1:0] chan [3];
    int                offs [3];
    int                len;
    int                ao;
    chan[0] = r;
    chan[1] = g;
    chan[2] = b;
    offs[0] = shadow_cfg.channel_offsets[4:0];
    offs[1] = shadow_cfg.channel_offsets[9:5];
    offs[2] = shadow_cfg.channel_offsets[14:10];
    ao      = shadow_cfg.channel_offsets[19:15];
    if (shadow_cfg.pixel_mode) begin
      w = 64'(ALPHA_FULL) << ao;
      for (int c = 0; c < 3; c++) w = w | (64'(chan[c]) << offs[c]);
      return w[WORD_W-1:0];
    end
    w = '0;
    for (int c = 0; c < 3; c++) begin
      len = shadow_cfg.channel_lengths[4*c +: 4];
      if (len > 8) len = 8;
      w = w | ((64'(chan[c]) >> (8 - len)) << offs[c]);
    end
    return {{(WORD_W-HALF_W){1'b0}}, w[HALF_W-1:0]};
  endfunction

  // Scan one dot and queue the writes it must produce
  function automatic void predict_dot_writes(input dot_t d);
    int           cx, cy, sz, h, x, y;
    int           wpx, hpx, px, py, stride;
    longint       addr, limit, bpp;
    logic [WORD_W-1:0] word;
    pixel_write_t batch[$];
    pixel_write_t pw;
    cx     = $signed(d.center_x);
    cy     = $signed(d.center_y);
    wpx    = shadow_cfg.width_px;
    hpx    = shadow_cfg.height_px;
    px     = shadow_cfg.pan_x;
    py     = shadow_cfg.pan_y;
    stride = shadow_cfg.line_bytes;
    limit  = longint'(stride) * longint'(hpx);
    bpp    = shadow_cfg.pixel_mode ? 4 : 2;
    sz     = d.diameter;
    if (sz > MAX_DIAMETER) sz = MAX_DIAMETER;
    h    = sz / 2;
    word = dot_colour(d.red, d.green, d.blue);
    for (int dx = -h; dx < h; dx++) begin
      for (int dy = -h; dy < h; dy++) begin
        x = cx + dx;
        y = cy + dy;
        if (dx * dx + dy * dy <= h * h && x >= 0 && x < wpx && y >= 0 && y < hpx) begin
          addr = (longint'(x) + px) * bpp + (longint'(y) + py) * stride;
          if (addr < limit && batch.size() < MAX_WRITES) begin
            pw.byte_address = addr[ADDR_W-1:0];
            pw.pixel_word   = word;
            pw.wide_write   = shadow_cfg.pixel_mode;
            pw.last_write   = 1'b0;
            batch.push_back(pw);
          end
        end
      end
    end
    if (batch.size() != 0) batch[batch.size()-1].last_write = 1'b1;
    foreach (batch[i]) pending_writes.push_back(batch[i]);
  endfunction

  // Track a register write the way the block decodes it
  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WIDTH:   shadow_cfg.width_px        = data[PIX_W-1:0];
      REG_HEIGHT:  shadow_cfg.height_px       = data[PIX_W-1:0];
      REG_PAN_X:   shadow_cfg.pan_x           = data[PIX_W-1:0];
      REG_PAN_Y:   shadow_cfg.pan_y           = data[PIX_W-1:0];
      REG_STRIDE:  shadow_cfg.line_bytes      = data[STRIDE_W-1:0];
      REG_MODE:    shadow_cfg.pixel_mode      = data[0];
      REG_OFFSETS: shadow_cfg.channel_offsets = data[OFFS_W-1:0];
      REG_LENGTHS: shadow_cfg.channel_lengths = data[LENS_W-1:0];
      default: ;
    endcase
  endfunction

  // Random bits above the register field
  function automatic logic [CFG_DATA_W-1:0] junk_above(input logic [CFG_DATA_W-1:0] v,
                                                       input int w);
    return ($urandom() << w) | v;
  endfunction

  function automatic cfg_t make_layout(input int w, input int hgt, input int px,
                                       input int py, input int stride, input int mode,
                                       input int offs, input int lens);
    cfg_t c;
    c.width_px        = PIX_W'(w);
    c.height_px       = PIX_W'(hgt);
    c.pan_x           = PIX_W'(px);
    c.pan_y           = PIX_W'(py);
    c.line_bytes      = STRIDE_W'(stride);
    c.pixel_mode      = 1'(mode);
    c.channel_offsets = OFFS_W'(offs);
    c.channel_lengths = LENS_W'(lens);
    return c;
  endfunction

  function automatic cfg_t random_layout(input layout_kind_t kind);
    int w, hgt, px, py, mode, bpp, stride, lens;
    if (kind == LAYOUT_FULL) return make_layout(4095, 4095, 4095, 4095, 16383, 1,
                                                20'hFFFFF, 12'hFFF);
    if (kind == LAYOUT_TINY) return make_layout(1, 1, 0, 0, 1, 0, 0, 0);
    w    = $urandom_range(1, 96);
    hgt  = $urandom_range(1, 64);
    px   = $urandom_range(0, 40);
    py   = $urandom_range(0, 40);
    mode = $urandom_range(0, 1);
    bpp  = mode ? 4 : 2;
    if ($urandom_range(0, 3) != 0) stride = (w + px) * bpp + $urandom_range(0, 16);
    else stride = $urandom_range(0, 16383);
    if ($urandom_range(0, 1) != 0) lens = $urandom_range(0, 4095);
    else lens = ($urandom_range(1, 8) << 8) | ($urandom_range(1, 8) << 4) |
                $urandom_range(1, 8);
    return make_layout(w, hgt, px, py, stride, mode, $urandom(), lens);
  endfunction

  function automatic dot_t make_dot(input int cx, input int cy, input int sz,
                                    input int r, input int g, input int b);
    dot_t d;
    d.center_x = COORD_W'(cx);
    d.center_y = COORD_W'(cy);
    d.diameter = SIZE_W'(sz);
    d.red      = CHAN_W'(r);
    d.green    = CHAN_W'(g);
    d.blue     = CHAN_W'(b);
    return d;
  endfunction

  // Mostly dots around the visible area, some anywhere
  function automatic dot_t random_dot(input cfg_t c);
    int cx, cy, sz;
    if ($urandom_range(0, 99) < 80) begin
      cx = int'($urandom_range(0, int'(c.width_px) + 15)) - 8;
      cy = int'($urandom_range(0, int'(c.height_px) + 15)) - 8;
      if ($urandom_range(0, 99) < 70) sz = $urandom_range(2, MAX_DIAMETER);
      else sz = $urandom_range(0, 15);
    end else begin
      cx = $urandom();
      cy = $urandom();
      sz = $urandom_range(0, 15);
    end
    return make_dot(cx, cy, sz, $urandom(), $urandom(), $urandom());
  endfunction

  // One register write transaction
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    store_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_layout(input cfg_t c);
    write_reg(REG_WIDTH,   junk_above(c.width_px, PIX_W));
    write_reg(REG_HEIGHT,  junk_above(c.height_px, PIX_W));
    write_reg(REG_PAN_X,   junk_above(c.pan_x, PIX_W));
    write_reg(REG_PAN_Y,   junk_above(c.pan_y, PIX_W));
    write_reg(REG_STRIDE,  junk_above(c.line_bytes, STRIDE_W));
    write_reg(REG_MODE,    junk_above(c.pixel_mode, 1));
    write_reg(REG_OFFSETS, junk_above(c.channel_offsets, OFFS_W));
    write_reg(REG_LENGTHS, junk_above(c.channel_lengths, LENS_W));
  endtask

  task automatic drain_writes();
    while (dot_queue.size() != 0 || pending_writes.size() != 0) @(posedge clk);
  endtask

  // Drained, and long enough that dots with no writes have finished too
  task automatic settle();
    drain_writes();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 77; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      default:       begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  // Driver: present queued dots and randomize write ready, on the falling edge
  always @(negedge clk) begin
    wr_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!dot_showing) begin
      if (dot_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd_ch.valid    <= 1'b1;
        cmd_ch.center_x <= dot_queue[0].center_x;
        cmd_ch.center_y <= dot_queue[0].center_y;
        cmd_ch.diameter <= dot_queue[0].diameter;
        cmd_ch.red      <= dot_queue[0].red;
        cmd_ch.green    <= dot_queue[0].green;
        cmd_ch.blue     <= dot_queue[0].blue;
        dot_showing = 1'b1;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: take commands into the predictor and check writes, on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      progress = 1'b0;
      if (cmd_ch.valid && cmd_ch.ready) begin
        taken_dot   = dot_queue.pop_front();
        dot_showing = 1'b0;
        predict_dot_writes(taken_dot);
        progress = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) progress = 1'b1;
      if (wr_ch.valid && wr_ch.ready) begin
        progress = 1'b1;
        seen_write.byte_address = wr_ch.byte_address;
        seen_write.pixel_word   = wr_ch.pixel_word;
        seen_write.wide_write   = wr_ch.wide_write;
        seen_write.last_write   = wr_ch.last_write;
        if (pending_writes.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected write: addr=%h word=%h wide=%b last=%b",
                     seen_write.byte_address, seen_write.pixel_word,
                     seen_write.wide_write, seen_write.last_write);
        end else begin
          want_write = pending_writes.pop_front();
          if (seen_write.byte_address !== want_write.byte_address ||
              seen_write.pixel_word !== want_write.pixel_word ||
              seen_write.wide_write !== want_write.wide_write ||
              seen_write.last_write !== want_write.last_write) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("write mismatch: exp addr=%h word=%h wide=%b last=%b",
                       want_write.byte_address, want_write.pixel_word,
                       want_write.wide_write, want_write.last_write);
              $display("                got addr=%h word=%h wide=%b last=%b",
                       seen_write.byte_address, seen_write.pixel_word,
                       seen_write.wide_write, seen_write.last_write);
            end
          end
        end
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus sequence
  initial begin
    cfg_t layout;
    cmd_ch.valid    = 1'b0;
    cmd_ch.center_x = '0;
    cmd_ch.center_y = '0;
    cmd_ch.diameter = '0;
    cmd_ch.red      = '0;
    cmd_ch.green    = '0;
    cmd_ch.blue     = '0;
    wr_ch.ready     = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    shadow_cfg      = '0;
    shadow_cfg.pixel_mode      = MODE_RESET;
    shadow_cfg.channel_offsets = OFFSETS_RESET;
    shadow_cfg.channel_lengths = LENGTHS_RESET;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset layout: zero-sized screen, nothing is written
    set_idling(IDLE_NONE);
    dot_queue.push_back(make_dot(0, 0, 8, 255, 255, 255));
    dot_queue.push_back(make_dot(1, 1, 4, 0, 0, 0));
    settle();

    // 64x48 at 32 bpp, default layout; every size, extreme centres
    write_reg(REG_UNUSED, $urandom());
    program_layout(make_layout(64, 48, 0, 0, 256, 1, OFFSETS_RESET, LENGTHS_RESET));
    dot_queue.push_back(make_dot(32, 24, 0, 255, 255, 255));
    dot_queue.push_back(make_dot(32, 24, 1, 255, 255, 255));
    dot_queue.push_back(make_dot(32, 24, 2, 0, 0, 0));
    dot_queue.push_back(make_dot(32, 24, 3, 255, 0, 0));
    dot_queue.push_back(make_dot(32, 24, 4, 0, 255, 0));
    dot_queue.push_back(make_dot(32, 24, 5, 0, 0, 255));
    dot_queue.push_back(make_dot(32, 24, 6, 170, 85, 170));
    dot_queue.push_back(make_dot(32, 24, 7, 85, 170, 85));
    dot_queue.push_back(make_dot(32, 24, 8, 255, 255, 255));
    dot_queue.push_back(make_dot(32, 24, 9, 18, 52, 86));   // oversized, clamps
    dot_queue.push_back(make_dot(32, 24, 15, 1, 128, 254));
    dot_queue.push_back(make_dot(0, 0, 8, 255, 255, 255));  // clipped at corners
    dot_queue.push_back(make_dot(63, 47, 8, 0, 0, 0));
    dot_queue.push_back(make_dot(-4096, -4096, 8, 255, 255, 255));
    dot_queue.push_back(make_dot(4095, 4095, 8, 255, 255, 255));
    dot_queue.push_back(make_dot(-4096, 24, 8, 0, 0, 0));
    dot_queue.push_back(make_dot(32, 4095, 8, 0, 0, 0));
    settle();

    // 16 bpp with a zero-length and an over-long channel, buffer limit cuts rows
    program_layout(make_layout(40, 20, 3, 2, 128, 0, 20'h000AB, 12'h5C0));
    dot_queue.push_back(make_dot(10, 18, 8, 255, 255, 255));
    dot_queue.push_back(make_dot(0, 10, 6, 170, 85, 255));
    dot_queue.push_back(make_dot(39, 0, 4, 1, 128, 200));
    dot_queue.push_back(make_dot(20, 19, 8, 255, 0, 255));
    settle();

    // 32 bpp with channels shifted past bit 31
    program_layout(make_layout(16, 16, 0, 0, 64, 1, 20'hF539F, LENGTHS_RESET));
    dot_queue.push_back(make_dot(8, 8, 8, 255, 255, 255));
    dot_queue.push_back(make_dot(15, 15, 3, 129, 66, 36));

    // Random phases: new layout and idling pattern each, with a drain midway
    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_idling(idle_mode_t'(p % 4));
      if (p == 3) layout = random_layout(LAYOUT_FULL);
      else if (p == 6) layout = random_layout(LAYOUT_TINY);
      else layout = random_layout(LAYOUT_TYPICAL);
      if (p == 5) write_reg(CFG_IDX_W'($urandom_range(8, 255)), $urandom());
      program_layout(layout);
      for (int i = 0; i < DOTS_PER_PHASE; i++) begin
        if (i == DOTS_PER_PHASE / 2) drain_writes();
        dot_queue.push_back(random_dot(layout));
      end
    end

    drain_writes();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_writes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
src/fdpw_pkg.sv
src/fdpw_cmd_if.sv
src/fdpw_wr_if.sv
src/fdpw_cfg_if.sv
src/fdpw_regs.sv
src/fdpw_front.sv
src/fdpw_queue.sv
src/fdpw_back.sv
src/filled_dot_pixel_writer.sv
bench/tb_filled_dot_pixel_writer.sv
